[hdl/status_bitstream_snapshot_ring_defines.svh]
// assertion macros shared by the snapshot ring modules
`ifndef STATUS_BITSTREAM_SNAPSHOT_RING_DEFINES_SVH
`define STATUS_BITSTREAM_SNAPSHOT_RING_DEFINES_SVH

// condition holds at every edge out of reset
`define SSR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence holds in the same cycle
`define SSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the next cycle
`define SSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ssr_pkg.sv]
// shared types, constants and helper functions of the snapshot ring
package ssr_pkg;

  localparam int RING_DEPTH = 2048;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  localparam logic [7:0]  MSG_TYPE_STATUS = 8'h17;
  localparam logic [31:0] MATCH_DIST_RST  = 32'd10000;
  localparam logic [21:0] POS_ZERO_CODE   = 22'd35;

  // configuration register indexes
  localparam logic CFG_DELAY = 1'b0;
  localparam logic CFG_MAXD  = 1'b1;

  // parser phases
  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_DISCARD    = 5'd1;
  localparam logic [4:0] PH_COUNT      = 5'd2;
  localparam logic [4:0] PH_HANDLE     = 5'd3;
  localparam logic [4:0] PH_TIME       = 5'd4;
  localparam logic [4:0] PH_FLAGS      = 5'd5;
  localparam logic [4:0] PH_PRE0       = 5'd6;
  localparam logic [4:0] PH_PRE7       = 5'd13;
  localparam logic [4:0] PH_X          = 5'd14;
  localparam logic [4:0] PH_Y          = 5'd15;
  localparam logic [4:0] PH_ZP         = 5'd16;
  localparam logic [4:0] PH_Z          = 5'd17;
  localparam logic [4:0] PH_POST0      = 5'd18;
  localparam logic [4:0] PH_POST9      = 5'd27;
  localparam logic [4:0] PH_EXTRA_P    = 5'd28;
  localparam logic [4:0] PH_EXTRA_SKIP = 5'd29;

  typedef enum logic [1:0] {PS_IDLE, PS_RUN, PS_LOOK, PS_STORE} pstate_t;
  typedef enum logic [1:0] {RS_IDLE, RS_QSCAN, RS_QEND, RS_LSCAN} rstate_t;

  typedef struct packed {
    logic [12:0] handle;
    logic [31:0] tick;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // parser to ring
  typedef struct packed {
    logic   st_req;
    logic   lk_req;
    entry_t ent;
  } ring_req_t;

  // ring to parser
  typedef struct packed {
    logic        st_done;
    logic        lk_done;
    logic        lk_hit;
    logic [31:0] lk_z;
  } ring_rsp_t;

  // bit length of each phase's field
  function automatic logic [6:0] phase_len(input logic [4:0] p);
    logic [6:0] l;
    unique case (p)
      5'd3:  l = 7'd13;
      5'd4:  l = 7'd32;
      5'd5:  l = 7'd20;
      5'd6:  l = 7'd2;
      5'd7:  l = 7'd3;
      5'd8:  l = 7'd10;
      5'd9, 5'd10, 5'd12, 5'd13: l = 7'd8;
      5'd11: l = 7'd9;
      5'd14, 5'd15, 5'd17: l = 7'd22;
      5'd16, 5'd28: l = 7'd1;
      5'd18: l = 7'd7;
      5'd19: l = 7'd2;
      5'd20: l = 7'd32;
      5'd21: l = 7'd36;
      5'd22, 5'd23, 5'd24, 5'd25: l = 7'd10;
      5'd26, 5'd29: l = 7'd72;
      5'd27: l = 7'd48;
      default: l = 7'd0;
    endcase
    return l;
  endfunction

  // flag bit that enables each trailing optional field
  function automatic logic [4:0] post_bit(input logic [3:0] i);
    logic [4:0] b;
    unique case (i)
      4'd0: b = 5'd11;
      4'd1: b = 5'd12;
      4'd2: b = 5'd9;
      4'd3: b = 5'd10;
      4'd4: b = 5'd13;
      4'd5: b = 5'd15;
      4'd6: b = 5'd16;
      4'd7: b = 5'd14;
      4'd8: b = 5'd17;
      default: b = 5'd18;
    endcase
    return b;
  endfunction

  // 22-bit packed coordinate to single precision bit pattern
  function automatic logic [31:0] decode22(input logic [21:0] v);
    logic [4:0]  e;
    logic [7:0]  expf;
    logic [31:0] r;
    e    = v[5:1];
    expf = 8'(8'h80 + {3'b000, e} - (e[4] ? 8'h20 : 8'h00));
    r    = {v[0], expf, v[21:6], 7'b0};
    if (v == POS_ZERO_CODE) r = 32'd0;
    return r;
  endfunction

endpackage

[hdl/status_bitstream_snapshot_ring.sv]
// top level of the status message snapshot ring
//
// channel  dir  handshake               payload
// in_      in   in_valid / in_ready     req_type, data_byte, last_byte, raw_tick, query
// out_     out  out_valid / out_ready   result_kind, found, handle, pos, visible_tick
// cfg_     in   cfg_we                  cfg_idx, cfg_wdata
//
// type and count bytes, and bytes of an ignored message, are handled in the idle state.
// record bytes are shifted in bit by bit, with a further step at each field boundary,
// each skipped optional field and each stored snapshot; a record without Z and with a
// nonzero handle adds a newest-first ring scan of up to ring fill entries.
// a query scans every filled ring entry through the single read port.
// a result waits in the output register while the next word is taken; the engine stalls
// only when a new result meets a full output register. reset empties the ring at once.
module status_bitstream_snapshot_ring (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_raw_tick,
  input  logic [12:0] in_query_handle,
  input  logic [31:0] in_query_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic        out_found,
  output logic [12:0] out_handle,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_visible_tick,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata
);
  import ssr_pkg::*;

  logic        p_idle;
  logic        r_busy;
  logic        in_fire;
  logic [31:0] delay_r, maxd_r;
  ring_req_t   rreq;
  ring_rsp_t   rrsp;
  entry_t      oent;

  assign in_ready = p_idle && !r_busy;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      maxd_r  <= MATCH_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DELAY: delay_r <= cfg_wdata;
        CFG_MAXD:  maxd_r  <= cfg_wdata;
        default:   delay_r <= delay_r;
      endcase
    end
  end

  ssr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && !in_req_type),
    .msg_byte (in_data_byte),
    .msg_last (in_last_byte),
    .raw_tick (in_raw_tick),
    .delay    (delay_r),
    .idle     (p_idle),
    .req      (rreq),
    .rsp      (rrsp)
  );

  ssr_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (rreq),
    .rsp       (rrsp),
    .q_start   (in_fire && in_req_type),
    .q_handle  (in_query_handle),
    .q_tick    (in_query_tick),
    .max_dist  (maxd_r),
    .busy      (r_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_result_kind),
    .out_found (out_found),
    .out_ent   (oent)
  );

  assign out_handle       = oent.handle;
  assign out_pos_x        = oent.x;
  assign out_pos_y        = oent.y;
  assign out_pos_z        = oent.z;
  assign out_visible_tick = oent.tick;
endmodule

[hdl/ssr_ram.sv]
// generic single write, single registered read memory
module ssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[hdl/ssr_parser.sv]
// bit-serial record parser of status messages
module ssr_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [7:0]        msg_byte,
  input  logic              msg_last,
  input  logic [31:0]       raw_tick,
  input  logic [31:0]       delay,
  output logic              idle,
  output ssr_pkg::ring_req_t req,
  input  ssr_pkg::ring_rsp_t rsp
);
  import ssr_pkg::*;

  pstate_t     ps_r, ps_nxt;
  logic [4:0]  phase_r, phase_nxt;
  logic [6:0]  bleft_r, bleft_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [19:0] flags_r, flags_nxt;
  logic [12:0] rh_r, rh_nxt;
  logic [7:0]  rleft_r, rleft_nxt;
  logic [31:0] hx_r, hx_nxt, hy_r, hy_nxt, z_r, z_nxt;
  logic [31:0] mtick_r, mtick_nxt;
  logic [7:0]  sr_r, sr_nxt;
  logic [3:0]  nbits_r, nbits_nxt;
  logic        last_r, last_nxt;
  logic        ent_r, ent_nxt;
  logic [6:0]  pos;
  logic [31:0] acc_v;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r    <= PS_IDLE;
      phase_r <= PH_IDLE;
      bleft_r <= '0;
      acc_r   <= '0;
      flags_r <= '0;
      rh_r    <= '0;
      rleft_r <= '0;
      hx_r    <= '0;
      hy_r    <= '0;
      mtick_r <= '0;
      nbits_r <= '0;
      ent_r   <= 1'b0;
    end else begin
      ps_r    <= ps_nxt;
      phase_r <= phase_nxt;
      bleft_r <= bleft_nxt;
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
      rh_r    <= rh_nxt;
      rleft_r <= rleft_nxt;
      hx_r    <= hx_nxt;
      hy_r    <= hy_nxt;
      mtick_r <= mtick_nxt;
      nbits_r <= nbits_nxt;
      ent_r   <= ent_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sr_r   <= sr_nxt;
    last_r <= last_nxt;
    z_r    <= z_nxt;
  end

  // field bit position of the bit being shifted in
  assign pos = 7'(phase_len(phase_r) - bleft_r);

  always_comb begin
    acc_v = acc_r;
    if (pos < 7'd32) acc_v[pos[4:0]] = sr_r[0];
  end

  // next state
  always_comb begin
    ps_nxt    = ps_r;
    phase_nxt = phase_r;
    bleft_nxt = bleft_r;
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    rh_nxt    = rh_r;
    rleft_nxt = rleft_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    z_nxt     = z_r;
    mtick_nxt = mtick_r;
    sr_nxt    = sr_r;
    nbits_nxt = nbits_r;
    last_nxt  = last_r;
    ent_nxt   = ent_r;
    unique case (ps_r)
      PS_IDLE: begin
        if (start) begin
          priority if (phase_r == PH_IDLE) begin
            mtick_nxt = raw_tick + delay;
            phase_nxt = (msg_byte == MSG_TYPE_STATUS) ? PH_COUNT : PH_DISCARD;
          end else if (phase_r == PH_COUNT) begin
            rleft_nxt = msg_byte;
            if (msg_byte == 8'd0) begin
              phase_nxt = PH_DISCARD;
            end else begin
              phase_nxt = PH_HANDLE;
              bleft_nxt = phase_len(PH_HANDLE);
              acc_nxt   = '0;
            end
          end else if (phase_r == PH_DISCARD) begin
            phase_nxt = PH_DISCARD;
          end else begin
            sr_nxt    = msg_byte;
            nbits_nxt = 4'd8;
            last_nxt  = msg_last;
            ps_nxt    = PS_RUN;
          end
          // short bytes close the message at once
          if (msg_last && (phase_r == PH_IDLE || phase_r == PH_COUNT ||
                           phase_r == PH_DISCARD)) begin
            phase_nxt = PH_IDLE;
            bleft_nxt = '0;
            acc_nxt   = '0;
          end
        end
      end
      PS_RUN: begin
        priority if (ent_r) begin
          // one step of the optional field skip chain
          priority if (phase_r >= PH_PRE0 && phase_r <= PH_PRE7) begin
            if (flags_r[3'(phase_r - PH_PRE0)]) begin
              ent_nxt   = 1'b0;
              bleft_nxt = phase_len(phase_r);
              acc_nxt   = '0;
            end else begin
              phase_nxt = 5'(phase_r + 5'd1);
            end
          end else if (phase_r == PH_X) begin
            if (flags_r[8]) begin
              ent_nxt   = 1'b0;
              bleft_nxt = phase_len(phase_r);
              acc_nxt   = '0;
            end else begin
              phase_nxt = PH_POST0;
            end
          end else if (phase_r >= PH_POST0 && phase_r <= PH_POST9) begin
            if (flags_r[post_bit(4'(phase_r - PH_POST0))]) begin
              ent_nxt   = 1'b0;
              bleft_nxt = phase_len(phase_r);
              acc_nxt   = '0;
            end else begin
              phase_nxt = 5'(phase_r + 5'd1);
            end
          end else if (phase_r == PH_EXTRA_P && !flags_r[19]) begin
            rleft_nxt = 8'(rleft_r - 8'd1);
            phase_nxt = (rleft_r == 8'd1) ? PH_DISCARD : PH_HANDLE;
          end else begin
            ent_nxt   = 1'b0;
            bleft_nxt = phase_len(phase_r);
            acc_nxt   = '0;
          end
        end else if (nbits_r != 4'd0 && phase_r != PH_DISCARD) begin
          // shift one bit into the current field
          sr_nxt    = {1'b0, sr_r[7:1]};
          nbits_nxt = 4'(nbits_r - 4'd1);
          bleft_nxt = 7'(bleft_r - 7'd1);
          acc_nxt   = acc_v;
          if (bleft_r == 7'd1) begin
            ent_nxt = 1'b1;
            priority if (phase_r == PH_HANDLE) begin
              rh_nxt    = acc_v[12:0];
              phase_nxt = PH_TIME;
            end else if (phase_r == PH_TIME) begin
              phase_nxt = PH_FLAGS;
            end else if (phase_r == PH_FLAGS) begin
              flags_nxt = acc_v[19:0];
              phase_nxt = PH_PRE0;
            end else if ((phase_r >= PH_PRE0 && phase_r <= PH_PRE7) ||
                         (phase_r >= PH_POST0 && phase_r <= PH_POST9)) begin
              phase_nxt = 5'(phase_r + 5'd1);
            end else if (phase_r == PH_X) begin
              hx_nxt    = decode22(acc_v[21:0]);
              phase_nxt = PH_Y;
            end else if (phase_r == PH_Y) begin
              hy_nxt    = decode22(acc_v[21:0]);
              phase_nxt = PH_ZP;
            end else if (phase_r == PH_ZP) begin
              if (acc_v[0]) begin
                phase_nxt = PH_Z;
              end else begin
                phase_nxt = PH_POST0;
                if (rh_r != 13'd0) ps_nxt = PS_LOOK;
              end
            end else if (phase_r == PH_Z) begin
              z_nxt     = decode22(acc_v[21:0]);
              phase_nxt = PH_POST0;
              if (rh_r != 13'd0) ps_nxt = PS_STORE;
            end else if (phase_r == PH_EXTRA_P && acc_v[0]) begin
              phase_nxt = PH_EXTRA_SKIP;
            end else begin
              rleft_nxt = 8'(rleft_r - 8'd1);
              phase_nxt = (rleft_r == 8'd1) ? PH_DISCARD : PH_HANDLE;
            end
          end
        end else begin
          // byte used up
          ps_nxt  = PS_IDLE;
          ent_nxt = 1'b0;
          if (last_r) begin
            phase_nxt = PH_IDLE;
            bleft_nxt = '0;
            acc_nxt   = '0;
          end
        end
      end
      PS_LOOK: begin
        if (rsp.lk_done) begin
          if (rsp.lk_hit) begin
            z_nxt  = rsp.lk_z;
            ps_nxt = PS_STORE;
          end else begin
            ps_nxt = PS_RUN;
          end
        end
      end
      PS_STORE: begin
        if (rsp.st_done) ps_nxt = PS_RUN;
      end
      default: ps_nxt = PS_IDLE;
    endcase
  end

  // requests to the ring
  assign idle           = (ps_r == PS_IDLE);
  assign req.st_req     = (ps_r == PS_STORE);
  assign req.lk_req     = (ps_r == PS_LOOK);
  assign req.ent.handle = rh_r;
  assign req.ent.tick   = mtick_r;
  assign req.ent.x      = hx_r;
  assign req.ent.y      = hy_r;
  assign req.ent.z      = z_r;
endmodule

[hdl/ssr_ring.sv]
// snapshot ring memory, scan engine and result register
module ssr_ring (
  input  logic               clk,
  input  logic               rst_n,
  input  ssr_pkg::ring_req_t req,
  output ssr_pkg::ring_rsp_t rsp,
  input  logic               q_start,
  input  logic [12:0]        q_handle,
  input  logic [31:0]        q_tick,
  input  logic [31:0]        max_dist,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic               out_found,
  output ssr_pkg::entry_t    out_ent
);
  import ssr_pkg::*;
  `include "status_bitstream_snapshot_ring_defines.svh"

  rstate_t            rs_r, rs_nxt;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [FILL_W-1:0]  cnt_r, cnt_nxt;
  logic [RING_AW-1:0] addr_r, addr_nxt;
  logic               iss_r;
  logic               issue;
  logic [RING_AW-1:0] raddr;
  logic [12:0]        qh_r;
  logic [31:0]        qt_r;
  logic               s2v_r, s2m_r;
  logic [31:0]        s2d_r;
  entry_t             s2e_r;
  logic               bf_r, bf_nxt;
  logic [31:0]        bd_r, bd_nxt;
  entry_t             be_r, be_nxt;
  logic               ov_r, ov_nxt;
  logic               ok_r, of_r;
  entry_t             oe_r;
  logic               free;
  logic               st_done;
  logic               q_fin;
  logic               q_hit;
  logic [ENTRY_W-1:0] rdata;
  entry_t             rd;

  assign rd      = entry_t'(rdata);
  assign free    = !ov_r || out_ready;
  assign st_done = (rs_r == RS_IDLE) && req.st_req && free;
  assign q_fin   = (rs_r == RS_QEND) && free;
  assign q_hit   = bf_r && (bd_r <= max_dist);

  // ring storage
  ssr_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_mem (
    .clk   (clk),
    .we    (st_done),
    .waddr (head_r),
    .wdata (req.ent),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  // scan control
  always_comb begin
    rs_nxt      = rs_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    cnt_nxt     = cnt_r;
    addr_nxt    = addr_r;
    issue       = 1'b0;
    raddr       = addr_r;
    rsp.st_done = st_done;
    rsp.lk_done = 1'b0;
    rsp.lk_hit  = 1'b0;
    rsp.lk_z    = rd.z;
    unique case (rs_r)
      RS_IDLE: begin
        cnt_nxt  = '0;
        addr_nxt = (head_r == '0) ? RING_AW'(RING_DEPTH - 1) : RING_AW'(head_r - 1'b1);
        if (st_done) begin
          head_nxt = (head_r == RING_AW'(RING_DEPTH - 1)) ? '0 : RING_AW'(head_r + 1'b1);
          if (fill_r != FILL_W'(RING_DEPTH)) fill_nxt = FILL_W'(fill_r + 1'b1);
        end else if (q_start) begin
          rs_nxt = RS_QSCAN;
        end else if (req.lk_req) begin
          rs_nxt = RS_LSCAN;
        end
      end
      RS_QSCAN: begin
        issue = (cnt_r < fill_r);
        raddr = cnt_r[RING_AW-1:0];
        if (issue) cnt_nxt = FILL_W'(cnt_r + 1'b1);
        if (!issue && !iss_r && !s2v_r) rs_nxt = RS_QEND;
      end
      RS_QEND: begin
        if (free) rs_nxt = RS_IDLE;
      end
      RS_LSCAN: begin
        // newest first, stop at the first handle match
        if (iss_r && rd.handle == req.ent.handle) begin
          rsp.lk_done = 1'b1;
          rsp.lk_hit  = 1'b1;
          rs_nxt      = RS_IDLE;
        end else begin
          issue = (cnt_r < fill_r);
          if (issue) begin
            cnt_nxt  = FILL_W'(cnt_r + 1'b1);
            addr_nxt = (addr_r == '0) ? RING_AW'(RING_DEPTH - 1) : RING_AW'(addr_r - 1'b1);
          end else if (!iss_r) begin
            rsp.lk_done = 1'b1;
            rs_nxt      = RS_IDLE;
          end
        end
      end
      default: rs_nxt = RS_IDLE;
    endcase
  end

  // best match tracking
  always_comb begin
    bf_nxt = bf_r;
    bd_nxt = bd_r;
    be_nxt = be_r;
    if (rs_r == RS_IDLE) begin
      bf_nxt = 1'b0;
    end else if (s2v_r && s2m_r && (!bf_r || s2d_r < bd_r)) begin
      bf_nxt = 1'b1;
      bd_nxt = s2d_r;
      be_nxt = s2e_r;
    end
  end

  // result register loading
  always_comb begin
    ov_nxt = ov_r;
    if (st_done || q_fin) ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r   <= RS_IDLE;
      head_r <= '0;
      fill_r <= '0;
      cnt_r  <= '0;
      iss_r  <= 1'b0;
      s2v_r  <= 1'b0;
      bf_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      rs_r   <= rs_nxt;
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
      iss_r  <= issue;
      s2v_r  <= (rs_r == RS_QSCAN) && iss_r;
      bf_r   <= bf_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    bd_r   <= bd_nxt;
    be_r   <= be_nxt;
    s2m_r  <= (rd.handle == qh_r);
    s2d_r  <= (rd.tick > qt_r) ? (rd.tick - qt_r) : (qt_r - rd.tick);
    s2e_r  <= rd;
    if (rs_r == RS_IDLE && q_start) begin
      qh_r <= q_handle;
      qt_r <= q_tick;
    end
    if (st_done) begin
      ok_r <= 1'b0;
      of_r <= 1'b1;
      oe_r <= req.ent;
    end else if (q_fin) begin
      ok_r <= 1'b1;
      of_r <= q_hit;
      oe_r <= q_hit ? be_r : '0;
    end
  end

  assign busy      = (rs_r != RS_IDLE);
  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_found = of_r;
  assign out_ent   = oe_r;

  // checks
  `SSR_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(RING_DEPTH), "ring fill beyond depth")
  `SSR_ASSERT_NXT(a_store_shown, st_done, ov_r && !ok_r, "stored snapshot not presented")
  `SSR_ASSERT_NXT(a_query_shown, q_fin, ov_r && ok_r && (rs_r == RS_IDLE),
                  "query answer not presented")
endmodule

[tb/sv/status_bitstream_snapshot_ring_tb.sv]
// testbench for the status message snapshot ring: random messages and queries
// checked against an in-bench prediction of ring contents and parser state
module testbench;
  import ssr_pkg::*;

  localparam int DEPTH = RING_DEPTH;

  typedef struct {
    bit        kind;
    bit        found;
    bit [12:0] handle;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit [31:0] tick;
  } snap_t;

  // scoreboard: prediction of parser and ring, queue of expected snapshots
  class snapshot_scoreboard;
    bit [31:0] delay_ms;
    bit [31:0] max_dist;
    bit [12:0] r_handle[DEPTH];
    bit [31:0] r_tick[DEPTH];
    bit [31:0] r_x[DEPTH];
    bit [31:0] r_y[DEPTH];
    bit [31:0] r_z[DEPTH];
    int        head;
    int        fill;
    bit [4:0]  phase;
    int        bits_left;
    bit [31:0] acc;
    bit [19:0] flags;
    bit [12:0] rec_handle;
    bit [7:0]  recs_left;
    bit [31:0] hx;
    bit [31:0] hy;
    bit [31:0] msg_tick;
    snap_t     pending[$];
    int        errors;

    function new();
      delay_ms = 0;
      max_dist = MATCH_DIST_RST;
      head = 0;
      fill = 0;
      phase = PH_IDLE;
      bits_left = 0;
      acc = 0;
      flags = 0;
      rec_handle = 0;
      recs_left = 0;
      hx = 0;
      hy = 0;
      msg_tick = 0;
      errors = 0;
    endfunction

    function int field_bits(bit [4:0] p);
      case (p)
        PH_HANDLE: return 13;
        PH_TIME: return 32;
        PH_FLAGS: return 20;
        5'd6: return 2;
        5'd7: return 3;
        5'd8: return 10;
        5'd9, 5'd10, 5'd12, 5'd13: return 8;
        5'd11: return 9;
        PH_X, PH_Y, PH_Z: return 22;
        PH_ZP, PH_EXTRA_P: return 1;
        5'd18: return 7;
        5'd19: return 2;
        5'd20: return 32;
        5'd21: return 36;
        5'd22, 5'd23, 5'd24, 5'd25: return 10;
        5'd26, PH_EXTRA_SKIP: return 72;
        5'd27: return 48;
        default: return 0;
      endcase
    endfunction

    function bit [4:0] trailing_flag(int i);
      case (i)
        0: return 11;
        1: return 12;
        2: return 9;
        3: return 10;
        4: return 13;
        5: return 15;
        6: return 16;
        7: return 14;
        8: return 17;
        default: return 18;
      endcase
    endfunction

    function bit [31:0] to_float(bit [21:0] v);
      bit [4:0] e;
      bit [7:0] ef;
      if (v == 22'd35) return 0;
      e = v[5:1];
      ef = e[4] ? 8'(8'h80 + e - 8'h20) : 8'(8'h80 + e);
      return {v[0], ef, v[21:6], 7'b0};
    endfunction

    function bit [4:0] finish_record();
      recs_left = 8'(recs_left - 8'd1);
      return (recs_left == 0) ? PH_DISCARD : PH_HANDLE;
    endfunction

    // move to a phase, skipping optional fields whose flag is clear
    function void go_to(bit [4:0] p);
      forever begin
        if (p >= PH_PRE0 && p <= PH_PRE7) begin
          if (flags[p - PH_PRE0]) break;
          p++;
        end else if (p == PH_X) begin
          if (flags[8]) break;
          p = PH_POST0;
        end else if (p >= PH_POST0 && p <= PH_POST9) begin
          if (flags[trailing_flag(p - PH_POST0)]) break;
          p++;
        end else if (p == PH_EXTRA_P) begin
          if (!flags[19]) p = finish_record();
          break;
        end else begin
          break;
        end
      end
      phase = p;
      bits_left = field_bits(p);
      acc = 0;
    endfunction

    function void push_snapshot(bit [31:0] z);
      snap_t s;
      if (rec_handle == 0) return;
      r_handle[head] = rec_handle;
      r_tick[head] = msg_tick;
      r_x[head] = hx;
      r_y[head] = hy;
      r_z[head] = z;
      head = (head + 1) % DEPTH;
      if (fill < DEPTH) fill++;
      s.kind = 0;
      s.found = 1;
      s.handle = rec_handle;
      s.x = hx;
      s.y = hy;
      s.z = z;
      s.tick = msg_tick;
      pending.insert(pending.size(), s);
    endfunction

    function void field_complete(bit [31:0] v);
      int idx;
      bit [4:0] p;
      p = phase;
      if (p == PH_HANDLE) begin
        rec_handle = v[12:0];
        go_to(PH_TIME);
      end else if (p == PH_TIME) begin
        go_to(PH_FLAGS);
      end else if (p == PH_FLAGS) begin
        flags = v[19:0];
        go_to(PH_PRE0);
      end else if (p >= PH_PRE0 && p <= PH_PRE7) begin
        go_to(5'(p + 5'd1));
      end else if (p == PH_X) begin
        hx = to_float(v[21:0]);
        go_to(PH_Y);
      end else if (p == PH_Y) begin
        hy = to_float(v[21:0]);
        go_to(PH_ZP);
      end else if (p == PH_ZP) begin
        if (v[0]) begin
          go_to(PH_Z);
        end else begin
          // borrow z from the newest entry of the same handle
          for (int off = 1; off <= fill; off++) begin
            idx = (head + DEPTH - off) % DEPTH;
            if (r_handle[idx] == rec_handle) begin
              push_snapshot(r_z[idx]);
              break;
            end
          end
          go_to(PH_POST0);
        end
      end else if (p == PH_Z) begin
        push_snapshot(to_float(v[21:0]));
        go_to(PH_POST0);
      end else if (p >= PH_POST0 && p <= PH_POST9) begin
        go_to(5'(p + 5'd1));
      end else if (p == PH_EXTRA_P) begin
        if (v[0]) go_to(PH_EXTRA_SKIP);
        else go_to(finish_record());
      end else begin
        go_to(finish_record());
      end
    endfunction

    // note one accepted input word
    function void note_word(bit rq, bit [7:0] b, bit lst, bit [31:0] rt, bit [12:0] qh,
                            bit [31:0] qt);
      snap_t s;
      bit hit;
      int best;
      bit [31:0] bd, d;
      int len;
      if (rq) begin
        hit = 0;
        best = 0;
        bd = 0;
        if (qh != 0) begin
          for (int i = 0; i < fill; i++) begin
            if (r_handle[i] != qh) continue;
            d = (r_tick[i] > qt) ? r_tick[i] - qt : qt - r_tick[i];
            if (!hit || d < bd) begin
              hit = 1;
              best = i;
              bd = d;
            end
          end
        end
        if (hit && bd > max_dist) hit = 0;
        s.kind = 1;
        s.found = hit;
        s.handle = hit ? r_handle[best] : 13'd0;
        s.x = hit ? r_x[best] : 32'd0;
        s.y = hit ? r_y[best] : 32'd0;
        s.z = hit ? r_z[best] : 32'd0;
        s.tick = hit ? r_tick[best] : 32'd0;
        pending.insert(pending.size(), s);
        return;
      end
      if (phase == PH_IDLE) begin
        msg_tick = 32'(rt + delay_ms);
        phase = (b == MSG_TYPE_STATUS) ? PH_COUNT : PH_DISCARD;
      end else if (phase == PH_COUNT) begin
        recs_left = b;
        if (b == 0) phase = PH_DISCARD;
        else go_to(PH_HANDLE);
      end else if (phase != PH_DISCARD) begin
        for (int k = 0; k < 8 && phase != PH_DISCARD; k++) begin
          len = field_bits(phase);
          if (len - bits_left < 32) acc[len - bits_left] = b[k];
          bits_left--;
          if (bits_left == 0) field_complete(acc);
        end
      end
      if (lst) begin
        phase = PH_IDLE;
        bits_left = 0;
        acc = 0;
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(snap_t a);
      snap_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind %0d handle %0h", $time, a.kind, a.handle);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.kind != e.kind) begin
        $display("%0t: kind exp %0d got %0d", $time, e.kind, a.kind);
        errors++;
      end
      if (a.found != e.found) begin
        $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
        errors++;
      end
      if (a.handle != e.handle) begin
        $display("%0t: handle exp %0h got %0h", $time, e.handle, a.handle);
        errors++;
      end
      if (a.x != e.x) begin
        $display("%0t: pos_x exp %08h got %08h", $time, e.x, a.x);
        errors++;
      end
      if (a.y != e.y) begin
        $display("%0t: pos_y exp %08h got %08h", $time, e.y, a.y);
        errors++;
      end
      if (a.z != e.z) begin
        $display("%0t: pos_z exp %08h got %08h", $time, e.z, a.z);
        errors++;
      end
      if (a.tick != e.tick) begin
        $display("%0t: visible_tick exp %08h got %08h", $time, e.tick, a.tick);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic [31:0] in_raw_tick;
  logic [12:0] in_query_handle;
  logic [31:0] in_query_tick;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic        out_found;
  logic [12:0] out_handle;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [31:0] out_pos_z;
  logic [31:0] out_visible_tick;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_wdata;

  snapshot_scoreboard board;
  bit [12:0]   used_handles[$];

  status_bitstream_snapshot_ring i_dut (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("status_bitstream_snapshot_ring test failed");
    $finish;
  end

  // result side: random stalls, check each accepted word
  initial begin
    snap_t a;
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      a.kind = out_result_kind;
      a.found = out_found;
      a.handle = out_handle;
      a.x = out_pos_x;
      a.y = out_pos_y;
      a.z = out_pos_z;
      a.tick = out_visible_tick;
      board.check_result(a);
    end
  end

  // send one word; valid stays up between back-to-back words
  task automatic send_word(bit rq, bit [7:0] b, bit lst, bit [31:0] rt, bit [12:0] qh,
                           bit [31:0] qt);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_data_byte <= b;
    in_last_byte <= lst;
    in_raw_tick <= rt;
    in_query_handle <= qh;
    in_query_tick <= qt;
    @(posedge clk iff in_ready);
    board.note_word(rq, b, lst, rt, qh, qt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 200) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [31:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DELAY) board.delay_ms = v;
    else board.max_dist = v;
    @(posedge clk);
  endtask

  task automatic send_query(bit [12:0] h, bit [31:0] t);
    send_word(1'b1, 8'($urandom), 1'($urandom), $urandom, h, t);
  endtask

  function automatic bit [12:0] pick_handle();
    if (used_handles.size() == 0 || $urandom_range(0, 3) == 0) return 13'($urandom);
    return used_handles[$urandom_range(0, used_handles.size() - 1)];
  endfunction

  function automatic int field_len_pre(int k);
    return board.field_bits(5'(PH_PRE0 + k));
  endfunction

  // build and send one status message as a bit list
  task automatic send_status(bit [31:0] rt, int nrec, bit cut_short, bit with_query);
    bit bits[$];
    bit [19:0] fl;
    bit [12:0] h;
    int nbytes;
    bit [7:0] b;
    send_word(1'b0, MSG_TYPE_STATUS, 1'b0, rt, 13'($urandom), $urandom);
    send_word(1'b0, nrec[7:0], nrec == 0, $urandom, 13'($urandom), $urandom);
    if (nrec == 0) return;
    for (int r = 0; r < nrec; r++) begin
      h = ($urandom_range(0, 15) == 0) ? 13'd0 : pick_handle();
      if (h != 0) used_handles.insert(used_handles.size(), h);
      for (int k = 0; k < 13; k++) bits.insert(bits.size(), h[k]);
      for (int k = 0; k < 32; k++) bits.insert(bits.size(), 1'($urandom));
      fl = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'h00100;
      fl[8] = ($urandom_range(0, 7) != 0);
      for (int k = 0; k < 20; k++) bits.insert(bits.size(), fl[k]);
      for (int k = 0; k < 8; k++)
        if (fl[k])
          for (int j = 0; j < field_len_pre(k); j++) bits.insert(bits.size(), 1'($urandom));
      if (fl[8]) begin
        for (int c = 0; c < 2; c++) begin
          bit [21:0] v;
          v = ($urandom_range(0, 9) == 0) ? 22'd35 : 22'($urandom);
          for (int k = 0; k < 22; k++) bits.insert(bits.size(), v[k]);
        end
        if ($urandom_range(0, 2) == 0) begin
          bits.insert(bits.size(), 1'b0);
        end else begin
          bit [21:0] v;
          v = 22'($urandom);
          bits.insert(bits.size(), 1'b1);
          for (int k = 0; k < 22; k++) bits.insert(bits.size(), v[k]);
        end
      end
      for (int i = 0; i < 10; i++)
        if (fl[board.trailing_flag(i)])
          for (int j = 0; j < board.field_bits(5'(PH_POST0 + i)); j++)
            bits.insert(bits.size(), 1'($urandom));
      if (fl[19]) begin
        bit ex;
        ex = 1'($urandom);
        bits.insert(bits.size(), ex);
        if (ex) for (int j = 0; j < 72; j++) bits.insert(bits.size(), 1'($urandom));
      end
    end
    nbytes = (bits.size() + 7) / 8;
    if (cut_short) nbytes = $urandom_range(1, (nbytes < 48) ? nbytes : 48);
    else nbytes += $urandom_range(0, 2);
    for (int i = 0; i < nbytes; i++) begin
      for (int k = 0; k < 8; k++)
        b[k] = (i * 8 + k < bits.size()) ? bits[i * 8 + k] : 1'($urandom);
      send_word(1'b0, b, i == nbytes - 1, $urandom, 13'($urandom), $urandom);
      if (with_query && $urandom_range(0, 5) == 0) send_query(pick_handle(), rt);
    end
  endtask

  // stimulus
  initial begin
    bit [31:0] t;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_data_byte = 8'd0;
    in_last_byte = 1'b0;
    in_raw_tick = 32'd0;
    in_query_handle = 13'd0;
    in_query_tick = 32'd0;
    cfg_we = 1'b0;
    cfg_idx = CFG_DELAY;
    cfg_wdata = 32'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring query, zero handle, foreign message, extremes
    send_query(13'd5, 32'd0);
    send_query(13'd0, 32'hFFFF_FFFF);
    send_word(1'b0, 8'h00, 1'b0, 32'hFFFF_FFFF, 13'h1FFF, 32'd0);
    send_word(1'b0, 8'hFF, 1'b1, 32'd0, 13'd0, 32'hFFFF_FFFF);
    send_status(32'd100, 0, 0, 0);
    send_status(32'd100, 1, 0, 0);
    send_status(32'hFFFF_FFF0, 3, 0, 1);
    send_status(32'd200, 2, 1, 0);
    send_status(32'd300, 255, 1, 0);
    send_query(pick_handle(), 32'd100);
    send_query(13'h1FFF, 32'd300);
    drain();

    // several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_DELAY, 32'hFFFF_FFFF); write_reg(CFG_MAXD, 32'd0); end
        1: begin write_reg(CFG_DELAY, 32'd0); write_reg(CFG_MAXD, 32'hFFFF_FFFF); end
        default: begin
          write_reg(CFG_DELAY, $urandom);
          write_reg(CFG_MAXD, $urandom_range(0, 400));
        end
      endcase
      for (int m = 0; m < 4; m++) begin
        t = (ph == 4) ? $urandom : $urandom_range(0, 2000);
        case ($urandom_range(0, 9))
          0: send_word(1'b0, 8'($urandom), 1'b1, $urandom, 13'($urandom), $urandom);
          1: send_status(t, $urandom_range(1, 2), 1, 1);
          2, 3: send_query(pick_handle(), t);
          default: send_status(t, $urandom_range(1, 2), 0, 1);
        endcase
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("status_bitstream_snapshot_ring test passed");
    else
      $display("status_bitstream_snapshot_ring test failed");
    $finish;
  end
endmodule
